/* hw/rtl/sktl_pkg.sv */
// ----------------------------------------------------------------------------
// sktl_pkg
// types, constants and command codes for the sorted key table leaf
// ----------------------------------------------------------------------------
package sktl_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int SLOT_BITS   = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = 64 + 32 + SLOT_BITS;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [63:0] search_key;
        logic [31:0]        entry_page_id;
        logic [15:0]        entry_slot_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_page_id;
        logic [15:0] found_slot_id;
        logic [8:0]  position;
        logic [8:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic               wr_new;
    } dp_cmd_t;

    typedef struct packed {
        logic               less;
        logic               equal;
    } dp_sts_t;

endpackage

/* hw/rtl/sktl_ram.sv */
// ----------------------------------------------------------------------------
// sktl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sktl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* hw/rtl/sktl_datapath.sv */
// ----------------------------------------------------------------------------
// sktl_datapath
// entry memory, key compare and shift write path
// ----------------------------------------------------------------------------
module sktl_datapath (
    input  logic                         aclk,
    input  sktl_pkg::req_t               req,
    input  sktl_pkg::dp_cmd_t            cmd,
    output sktl_pkg::dp_sts_t            sts,
    output logic [31:0]                  rd_page,
    output logic [15:0]                  rd_slot
);
    logic [sktl_pkg::ENTRY_W-1:0] rd_data;
    logic [sktl_pkg::ENTRY_W-1:0] wr_data;
    logic signed [63:0]           rd_key;
    logic [sktl_pkg::SLOT_BITS-1:0] new_slot;

    assign new_slot = req.entry_slot_id[sktl_pkg::SLOT_BITS-1:0];
    assign wr_data  = cmd.wr_new ? {req.search_key, req.entry_page_id, new_slot} : rd_data;

    sktl_ram #(.WIDTH(sktl_pkg::ENTRY_W), .DEPTH(sktl_pkg::MAX_ENTRIES)) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = signed'(rd_data[sktl_pkg::ENTRY_W-1 -: 64]);
    assign rd_page   = rd_data[sktl_pkg::SLOT_BITS +: 32];
    assign rd_slot   = 16'(rd_data[sktl_pkg::SLOT_BITS-1:0]);
    assign sts.less  = rd_key < req.search_key;
    assign sts.equal = rd_key == req.search_key;
endmodule

/* hw/rtl/sktl_ctrl.sv */
// ----------------------------------------------------------------------------
// sktl_ctrl
// sequencer: binary search, shift passes and response
// ----------------------------------------------------------------------------
module sktl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sktl_pkg::req_t      s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sktl_pkg::rsp_t      m_data,
    output sktl_pkg::req_t      req,
    output sktl_pkg::dp_cmd_t   cmd,
    input  sktl_pkg::dp_sts_t   sts,
    input  logic [31:0]         rd_page,
    input  logic [15:0]         rd_slot
);
    localparam int CW = sktl_pkg::CNT_W;
    localparam int AW = sktl_pkg::ADDR_W;

    typedef enum logic [2:0] {
        IDLE, SRCH_RD, SRCH_CMP, HIT_RD, HIT_CHK, SHIFT_RD, SHIFT_WR, RESP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg, lo_reg, hi_reg, idx_reg;
    sktl_pkg::req_t  req_reg;
    sktl_pkg::rsp_t  rsp_reg;
    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid;
    logic            hit;
    logic [1:0]      chk_status;
    logic [31:0]     chk_page;
    logic [15:0]     chk_slot;
    logic [CW-1:0]   chk_count, chk_idx;
    state_t          chk_state;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign req     = req_reg;
    assign s_ready = (state_reg == IDLE) && !m_valid;
    assign m_valid = (state_reg == RESP);
    assign m_data  = rsp_reg;
    assign hit     = (lo_reg < count_reg) && sts.equal;

    always_comb begin
        cmd = '0;
        case (state_reg)
            SRCH_RD:  cmd.rd_addr = mid[AW-1:0];
            HIT_RD:   cmd.rd_addr = lo_reg[AW-1:0];
            SHIFT_RD: begin
                if (req_reg.cmd == sktl_pkg::CMD_INSERT) begin
                    cmd.rd_addr = AW'(idx_reg - 1'b1);
                end else begin
                    cmd.rd_addr = AW'(idx_reg + 1'b1);
                end
            end
            SHIFT_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg[AW-1:0];
                cmd.wr_new  = (req_reg.cmd == sktl_pkg::CMD_INSERT) && (idx_reg == lo_reg);
            end
            default: ;
        endcase
    end

    // outcome of the search, taken in HIT_CHK
    always_comb begin
        chk_status = sktl_pkg::ST_DONE;
        chk_page   = '0;
        chk_slot   = '0;
        chk_count  = count_reg;
        chk_idx    = lo_reg;
        chk_state  = RESP;
        case (req_reg.cmd)
            sktl_pkg::CMD_INSERT: begin
                if (count_reg == CW'(sktl_pkg::MAX_ENTRIES)) begin
                    chk_status = sktl_pkg::ST_FULL;
                end else begin
                    chk_idx   = count_reg;
                    chk_count = count_reg + 1'b1;
                    chk_state = (count_reg == lo_reg) ? SHIFT_WR : SHIFT_RD;
                end
            end
            sktl_pkg::CMD_LOOKUP: begin
                if (hit) begin
                    chk_page = rd_page;
                    chk_slot = rd_slot;
                end else begin
                    chk_status = sktl_pkg::ST_NOTFOUND;
                end
            end
            sktl_pkg::CMD_REMOVE: begin
                if (hit) begin
                    chk_count = count_reg - 1'b1;
                    chk_state = (lo_reg + 1'b1 < count_reg) ? SHIFT_RD : RESP;
                end else begin
                    chk_status = sktl_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        lo_reg    <= '0;
                        hi_reg    <= count_reg;
                        state_reg <= (count_reg == '0) ? HIT_CHK : SRCH_RD;
                    end
                end
                SRCH_RD:  state_reg <= SRCH_CMP;
                SRCH_CMP: begin
                    if (sts.less) begin
                        lo_reg <= mid + 1'b1;
                        state_reg <= (mid + 1'b1 < hi_reg) ? SRCH_RD : HIT_RD;
                    end else begin
                        hi_reg <= mid;
                        state_reg <= (lo_reg < mid) ? SRCH_RD : HIT_RD;
                    end
                end
                HIT_RD:   state_reg <= HIT_CHK;
                HIT_CHK: begin
                    rsp_reg   <= '{chk_status, chk_page, chk_slot, 9'(lo_reg), 9'(chk_count)};
                    idx_reg   <= chk_idx;
                    count_reg <= chk_count;
                    state_reg <= chk_state;
                end
                SHIFT_RD: state_reg <= SHIFT_WR;
                SHIFT_WR: begin
                    if (req_reg.cmd == sktl_pkg::CMD_INSERT) begin
                        if (idx_reg == lo_reg) begin
                            state_reg <= RESP;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= (idx_reg - 1'b1 == lo_reg) ? SHIFT_WR : SHIFT_RD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 2'd2 < count_reg + 1'b1) ? SHIFT_RD : RESP;
                    end
                end
                RESP: if (m_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(sktl_pkg::MAX_ENTRIES)) else $error("count overflow");
    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SRCH_RD) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search window broken");
    a_resp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(rsp_reg)))
        else $error("response changed while stalled");
endmodule

/* hw/rtl/sorted_key_table_leaf.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_leaf
// sorted table of signed keys with record ids: insert, lookup, remove
// ----------------------------------------------------------------------------
// a request enters on s_valid/s_ready carrying cmd, key and record id; one
// response leaves on m_valid/m_ready with status, record id, lower-bound
// position and entry count.
// one request is handled at a time. the lower-bound search reads the entry
// memory and then compares for each halving step (SRCH_RD, SRCH_CMP), and
// an insert or remove then moves the later entries one at a time through the
// entry memory's registered read port, read then write (SHIFT_RD, SHIFT_WR).
// reset clears the state and the entry count only; the entry memory needs no
// clearing pass since only entries below the count are used.
// a stalled receiver holds the response in its register; s_ready stays low
// until it is taken.
// ----------------------------------------------------------------------------
module sorted_key_table_leaf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sktl_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sktl_pkg::rsp_t  m_data
);
    sktl_pkg::req_t    req;
    sktl_pkg::dp_cmd_t cmd;
    sktl_pkg::dp_sts_t sts;
    logic [31:0]       rd_page;
    logic [15:0]       rd_slot;

    sktl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .req(req), .cmd(cmd), .sts(sts), .rd_page(rd_page), .rd_slot(rd_slot)
    );

    sktl_datapath u_dp (
        .aclk(aclk), .req(req), .cmd(cmd), .sts(sts),
        .rd_page(rd_page), .rd_slot(rd_slot)
    );
endmodule
